// ===== sv/rfp_pkg.sv =====
`timescale 1ns / 1ps

package rfp_pkg;

   // Frame layout: header, five data bytes, checksum.
   localparam int FRAME_LEN   = 7;
   localparam int SUM_LEN     = 6;
   localparam int BYTE_W      = 8;
   localparam int DIST_W      = 16;
   localparam int FILL_W      = 3;
   localparam int DIST_HI_POS = 4;
   localparam int DIST_LO_POS = 5;
   localparam int CHECK_POS   = 6;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h5A;

   // One received byte moving from the input register to the frame engine.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } rx_item_type;

   // Outcome of one processed byte.
   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] distance_cm;
   } frame_result_type;

endpackage

// ===== sv/rfp_in_stage.sv =====
`timescale 1ns / 1ps

module rfp_in_stage
   import rfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              advance,
   output rx_item_type       item
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;

   // The register can take a new transaction when empty or when its byte moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

// ===== sv/rfp_frame_engine.sv =====
`timescale 1ns / 1ps

module rfp_frame_engine
   import rfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  rx_item_type      item,
   output frame_result_type result
);

   logic [BYTE_W-1:0] store_ff [FRAME_LEN];
   logic [BYTE_W-1:0] store_in [FRAME_LEN];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   logic [BYTE_W-1:0] merged  [FRAME_LEN];
   logic [BYTE_W-1:0] shifted [FRAME_LEN];
   logic [BYTE_W-1:0] sum;
   logic [FILL_W-1:0] hdr_pos;
   logic              hdr_found;
   logic              full;
   logic              hit;

   // Place the byte at the fill position, then resolve the frame once it is complete.
   always_comb begin
      for (int i = 0; i < FRAME_LEN; i++) begin
         merged[i] = store_ff[i];
      end
      merged[fill_ff] = item.rx_byte;

      full = (fill_ff == FILL_W'(FRAME_LEN - 1));

      // Wrapping checksum over the header and data bytes.
      sum = '0;
      for (int k = 0; k < SUM_LEN; k++) begin
         sum = BYTE_W'(sum + store_ff[k]);
      end

      // First header byte from position one onward.
      hdr_found = 1'b0;
      hdr_pos   = '0;
      for (int p = FRAME_LEN - 1; p >= 1; p--) begin
         if (merged[p] == HEADER_BYTE) begin
            hdr_found = 1'b1;
            hdr_pos   = FILL_W'(p);
         end
      end

      // Shift the buffer down so it starts at that header byte.
      for (int i = 0; i < FRAME_LEN; i++) begin
         shifted[i] = merged[i];
         for (int p = 1; p < FRAME_LEN - i; p++) begin
            if (hdr_pos == FILL_W'(p)) begin
               shifted[i] = merged[i + p];
            end
         end
      end

      hit = 1'b0;
      for (int i = 0; i < FRAME_LEN; i++) begin
         store_in[i] = merged[i];
      end
      priority if (fill_ff == '0) begin
         // An empty buffer only takes a header byte.
         fill_in = (item.rx_byte == HEADER_BYTE) ? FILL_W'(1) : '0;
      end else if (!full) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (item.rx_byte == sum) begin
         hit     = 1'b1;
         fill_in = '0;
      end else if (hdr_found) begin
         for (int i = 0; i < FRAME_LEN; i++) begin
            store_in[i] = shifted[i];
         end
         fill_in = FILL_W'(FRAME_LEN) - hdr_pos;
      end else begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (fire) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < FRAME_LEN; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   assign result.valid       = fire && hit;
   assign result.distance_cm = {store_ff[DIST_HI_POS], store_ff[DIST_LO_POS]};

   // The fill count stays below a whole frame between transactions.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAME_LEN - 1))
      else $error("frame fill count out of range");

   // A held partial frame always starts with the header byte.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff != '0 |-> store_ff[0] == HEADER_BYTE)
      else $error("partial frame does not start with header");

   // A distance is only reported when the byte completes a frame.
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> fill_ff == FILL_W'(FRAME_LEN - 1) && item.rx_byte == sum)
      else $error("distance reported from an incomplete frame");

   // A good frame leaves the buffer empty.
   assert property (@(posedge clock) disable iff (reset)
      result.valid |=> fill_ff == '0)
      else $error("buffer not cleared after a good frame");

endmodule

// ===== sv/rfp_out_stage.sv =====
`timescale 1ns / 1ps

module rfp_out_stage
   import rfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  frame_result_type  result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance_cm
);

   logic              valid_ff;
   logic              valid_in;
   logic [DIST_W-1:0] dist_ff;

   // The pipeline moves whenever the result register is empty or being emptied.
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         dist_ff <= result.distance_cm;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_distance_cm = dist_ff;

endmodule

// ===== sv/range_frame_parser_resync.sv =====
`timescale 1ns / 1ps

// Rangefinder serial frame parser. Each request transaction carries one received
// byte; bytes are collected into seven-byte frames that start with the header 0x5A
// and end with an 8-bit wrapping sum of the first six bytes. A frame with a good
// checksum yields one response transaction with the big-endian distance in
// centimetres from bytes four and five; a bad frame yields nothing and the buffer
// restarts at the next header byte inside it. The block takes one byte per clock
// cycle at full rate: a byte is registered at the input, resolved against the frame
// buffer once the output register can move, and its result, if any, is captured in
// the output register at the end of that same cycle. Only a response waiting in the
// output register that is not taken stalls the input.
module range_frame_parser_resync
   import rfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance_cm
);

   rx_item_type      item;
   frame_result_type result;
   logic             advance;
   logic             fire;

   // A registered byte is processed when the result register can move.
   assign fire = item.valid && advance;

   rfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item        (item)
   );

   rfp_frame_engine u_frame_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   rfp_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance_cm (rsp_distance_cm)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rfp_pkg::*;

   localparam int MAX_GAP      = 18;
   localparam int RANDOM_BYTES = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   // Tracks the frame buffer of the parser and the distances it still owes.
   class distance_scoreboard;
      logic [BYTE_W-1:0] frame_bytes [FRAME_LEN] = '{default: '0};
      int held_count = 0;
      logic [DIST_W-1:0] pending_distances [$];
      int error_count = 0;

      // Drop everything before the next header at position one or later.
      function void realign_to_header();
         int n;
         int pos;
         int j;
         n = held_count;
         for (pos = 1; pos < n; pos++) begin
            if (frame_bytes[pos] == HEADER_BYTE) begin
               for (j = 0; j < n - pos; j++) begin
                  frame_bytes[j] = frame_bytes[j + pos];
               end
               held_count = n - pos;
               return;
            end
         end
         held_count = 0;
      endfunction

      // Apply one accepted request transaction and queue any distance it yields.
      function void note_rx_byte(logic [BYTE_W-1:0] value);
         logic [BYTE_W-1:0] sum;
         int k;
         if (held_count < FRAME_LEN) begin
            frame_bytes[held_count] = value;
            held_count++;
         end
         if (frame_bytes[0] != HEADER_BYTE) begin
            realign_to_header();
            if (held_count == 0) return;
         end
         if (held_count < FRAME_LEN) return;
         sum = '0;
         for (k = 0; k < SUM_LEN; k++) begin
            sum = BYTE_W'(sum + frame_bytes[k]);
         end
         if (frame_bytes[CHECK_POS] != sum) begin
            realign_to_header();
            return;
         end
         pending_distances.push_back({frame_bytes[DIST_HI_POS], frame_bytes[DIST_LO_POS]});
         held_count = 0;
      endfunction

      // Compare one response transaction with the oldest expected distance.
      function void check_distance(logic [DIST_W-1:0] actual);
         logic [DIST_W-1:0] expected;
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected distance, expected none, actual %04h", $time, actual);
            error_count++;
            return;
         end
         expected = pending_distances.pop_front();
         if (actual !== expected) begin
            $display("%0t: distance mismatch, expected %04h, actual %04h",
                     $time, expected, actual);
            error_count++;
         end
      endfunction

      function int pending_count();
         return pending_distances.size();
      endfunction

      function void report_leftovers();
         if (pending_distances.size() != 0) begin
            $display("%0t: %0d distances missing, expected %04h next, actual none",
                     $time, pending_distances.size(), pending_distances[0]);
            error_count++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DIST_W-1:0] rsp_distance_cm;

   distance_scoreboard board = new();
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;
   int cycle_count;

   range_frame_parser_resync DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance_cm (rsp_distance_cm)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one byte after a random gap and hold it until it is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      board.note_rx_byte(value);
   endtask

   // Send the first count bytes of a frame.
   task automatic send_frame(input logic [FRAME_LEN-1:0][BYTE_W-1:0] frame, input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_byte(frame[i]);
      end
   endtask

   // Response side: random stalls, with stretches of back-to-back acceptance.
   initial begin : rsp_side
      int gap;
      forever begin
         gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid || reset);
         board.check_distance(rsp_distance_cm);
         if ($urandom_range(0, 7) == 0) take_burst = !take_burst;
      end
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] directed_seq [$];
      logic [FRAME_LEN-1:0][BYTE_W-1:0] frame;
      logic [BYTE_W-1:0] sum;
      int frame_bytes_sent;
      int kind;
      int i;
      int count;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Noise into an empty buffer, zero and full-scale distances with a
      // wrapping checksum, then a bad frame whose inner header restarts a
      // frame that the next two bytes complete.
      directed_seq = {8'h00, 8'hFF,
                      8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A,
                      8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55,
                      8'h5A, 8'h01, 8'h5A, 8'h02, 8'h03, 8'h04, 8'h00,
                      8'h12, 8'h75};
      foreach (directed_seq[d]) send_byte(directed_seq[d]);

      // Mostly well-formed frames with random content, plus bad checksums,
      // cut-off frames and line noise.
      frame_bytes_sent = 0;
      while (frame_bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) == 0) send_burst = !send_burst;
         frame[0] = HEADER_BYTE;
         for (i = 1; i < FRAME_LEN; i++) frame[i] = BYTE_W'($urandom_range(0, 255));
         case ($urandom_range(0, 5))
            0: {frame[DIST_HI_POS], frame[DIST_LO_POS]} = '0;
            1: {frame[DIST_HI_POS], frame[DIST_LO_POS]} = '1;
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) frame[$urandom_range(1, SUM_LEN - 1)] = HEADER_BYTE;
         sum = '0;
         for (i = 0; i < SUM_LEN; i++) sum = BYTE_W'(sum + frame[i]);
         frame[CHECK_POS] = sum;
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            send_frame(frame, FRAME_LEN);
            frame_bytes_sent += FRAME_LEN;
         end else if (kind < 75) begin
            frame[CHECK_POS] = sum ^ BYTE_W'($urandom_range(1, 255));
            send_frame(frame, FRAME_LEN);
            frame_bytes_sent += FRAME_LEN;
         end else if (kind < 87) begin
            count = $urandom_range(1, FRAME_LEN - 1);
            send_frame(frame, count);
            frame_bytes_sent += count;
         end else begin
            count = $urandom_range(1, 4);
            for (i = 0; i < count; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      // Drain the responses still owed.
      while (board.pending_count() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.report_leftovers();
      if (board.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
